// ----- sv/lpnm_pkg.sv -----
// ============================================================================
// lpnm_pkg: shared types and constants of the local peak neighbor mean filter
// Payload structs, widths, register map, command codes and the small
// constant tables used by the mean divider.
// ============================================================================
package lpnm_pkg;

    // frame geometry
    localparam int MAX_SIZE   = 256;
    localparam int MIN_SIZE   = 2;
    localparam int SIZE_W     = 9;
    localparam int ADDR_W     = $clog2(MAX_SIZE);
    localparam int COORD_W    = 8;

    // pixel and result widths
    localparam int PIX_W      = 16;
    localparam int FRAC_W     = 8;
    localparam int VAL_W      = PIX_W + FRAC_W;
    localparam int SUM_W      = PIX_W + 3;
    localparam int MAG_W      = SUM_W;
    localparam int CNT_W      = 4;
    localparam int REM_W      = 3;

    // reciprocal multiply for the neighbor mean
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = 21;
    localparam int Q_W         = MAG_W + RECIP_W - RECIP_SHIFT;

    // neighbor counts: corner, border and interior pixels
    localparam int NB_CORNER  = 3;
    localparam int NB_EDGE    = 5;
    localparam int NB_FULL    = 8;
    localparam logic [CNT_W-1:0] CNT_CORNER = CNT_W'(NB_CORNER);
    localparam logic [CNT_W-1:0] CNT_EDGE   = CNT_W'(NB_EDGE);
    localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(NB_FULL);

    localparam logic [RECIP_W-1:0] RECIP_CORNER =
        RECIP_W'((2 ** RECIP_SHIFT + NB_CORNER - 1) / NB_CORNER);
    localparam logic [RECIP_W-1:0] RECIP_EDGE =
        RECIP_W'((2 ** RECIP_SHIFT + NB_EDGE - 1) / NB_EDGE);
    localparam logic [RECIP_W-1:0] RECIP_FULL =
        RECIP_W'((2 ** RECIP_SHIFT + NB_FULL - 1) / NB_FULL);

    localparam int FRAC_UNIT = 2 ** FRAC_W;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_SIZE = REG_IDX_W'(0);
    localparam logic [SIZE_W-1:0]    FRAME_SIZE_RESET = SIZE_W'(MAX_SIZE);

    // item commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic                    command;
        logic signed [PIX_W-1:0] pixel;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    replaced;
        logic [COORD_W-1:0]      row;
        logic [COORD_W-1:0]      column;
        logic                    frame_end;
    } result_t;

    // neighborhood summary handed to the mean divider
    typedef struct packed {
        logic signed [PIX_W-1:0] center;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
        logic                    peak;
        logic [COORD_W-1:0]      row;
        logic [COORD_W-1:0]      column;
        logic                    frame_end;
    } peak_t;

    // reciprocal of the neighbor count, scaled by 2**RECIP_SHIFT and rounded up
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        case (count)
            CNT_CORNER: r = RECIP_CORNER;
            CNT_EDGE:   r = RECIP_EDGE;
            default:    r = RECIP_FULL;
        endcase
        return r;
    endfunction

    // floor(rem * 256 / count) for a remainder below the count
    function automatic logic [FRAC_W-1:0] frac_of(input logic [CNT_W-1:0] count,
                                                  input logic [REM_W-1:0] rem);
        logic [FRAC_W-1:0] f;
        f = '0;
        case (count)
            CNT_CORNER:
            begin
                case (rem)
                    3'd1:    f = FRAC_W'(FRAC_UNIT / NB_CORNER);
                    3'd2:    f = FRAC_W'(2 * FRAC_UNIT / NB_CORNER);
                    default: f = '0;
                endcase
            end
            CNT_EDGE:
            begin
                case (rem)
                    3'd1:    f = FRAC_W'(FRAC_UNIT / NB_EDGE);
                    3'd2:    f = FRAC_W'(2 * FRAC_UNIT / NB_EDGE);
                    3'd3:    f = FRAC_W'(3 * FRAC_UNIT / NB_EDGE);
                    3'd4:    f = FRAC_W'(4 * FRAC_UNIT / NB_EDGE);
                    default: f = '0;
                endcase
            end
            default: f = {rem, {(FRAC_W - REM_W){1'b0}}};
        endcase
        return f;
    endfunction

endpackage

// ----- sv/lpnm_mean.sv -----
// ============================================================================
// lpnm_mean: neighbor mean divider and result register
// Takes a neighborhood summary, divides the neighbor sum scaled by 256 by
// the neighbor count (truncated toward zero) and forms the output transfer.
// Three register stages: summary, quotient, result.
// ============================================================================
module lpnm_mean (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              peak_valid,
    output logic              peak_ready,
    input  lpnm_pkg::peak_t   peak_in,
    output logic              result_valid,
    input  logic              result_ready,
    output lpnm_pkg::result_t result
);
    import lpnm_pkg::*;

    typedef struct packed {
        logic [Q_W-1:0]          quot;
        logic [MAG_W-1:0]        mag;
        logic                    neg;
        logic [CNT_W-1:0]        count;
        logic                    peak;
        logic signed [PIX_W-1:0] center;
        logic [COORD_W-1:0]      row;
        logic [COORD_W-1:0]      column;
        logic                    frame_end;
    } quot_t;

    peak_t   b_reg;
    logic    b_valid_reg;
    quot_t   c_reg;
    quot_t   c_next;
    logic    c_valid_reg;
    result_t out_reg;
    result_t out_next;
    logic    out_valid_reg;

    logic b_free;
    logic c_free;
    logic out_free;

    logic [MAG_W-1:0]             b_mag;
    logic [MAG_W+RECIP_W-1:0]     b_prod;
    logic [MAG_W-1:0]             c_qd;
    logic [MAG_W-1:0]             c_diff;
    logic [REM_W-1:0]             c_rem;
    logic [Q_W+FRAC_W-1:0]        c_mean_mag;
    logic [Q_W+FRAC_W-1:0]        c_mean;

    // stage flow: a stage loads when empty or when its content moves on
    assign out_free   = !out_valid_reg || result_ready;
    assign c_free     = !c_valid_reg || out_free;
    assign b_free     = !b_valid_reg || c_free;
    assign peak_ready = b_free;

    // magnitude of the sum times the reciprocal of the count
    always_comb
    begin
        b_mag  = b_reg.sum[SUM_W-1] ? MAG_W'(-b_reg.sum) : MAG_W'(b_reg.sum);
        b_prod = (MAG_W + RECIP_W)'(b_mag) * (MAG_W + RECIP_W)'(recip_of(b_reg.count));

        c_next.quot      = b_prod[RECIP_SHIFT +: Q_W];
        c_next.mag       = b_mag;
        c_next.neg       = b_reg.sum[SUM_W-1];
        c_next.count     = b_reg.count;
        c_next.peak      = b_reg.peak;
        c_next.center    = b_reg.center;
        c_next.row       = b_reg.row;
        c_next.column    = b_reg.column;
        c_next.frame_end = b_reg.frame_end;
    end

    // remainder gives the fraction bits, then restore the sign
    always_comb
    begin
        c_qd       = MAG_W'(c_reg.quot) * MAG_W'(c_reg.count);
        c_diff     = c_reg.mag - c_qd;
        c_rem      = c_diff[REM_W-1:0];
        c_mean_mag = {c_reg.quot, frac_of(c_reg.count, c_rem)};
        c_mean     = c_reg.neg ? (Q_W + FRAC_W)'(-c_mean_mag) : c_mean_mag;

        if (c_reg.peak)
        begin
            out_next.value = VAL_W'(c_mean);
        end
        else
        begin
            out_next.value = {c_reg.center, {FRAC_W{1'b0}}};
        end
        out_next.replaced  = c_reg.peak;
        out_next.row       = c_reg.row;
        out_next.column    = c_reg.column;
        out_next.frame_end = c_reg.frame_end;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_free)
            begin
                b_valid_reg <= peak_valid;
            end
            if (c_free)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= c_valid_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (peak_valid && b_free)
        begin
            b_reg <= peak_in;
        end
        if (b_valid_reg && c_free)
        begin
            c_reg <= c_next;
        end
        if (c_valid_reg && out_free)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // the reciprocal quotient must be exact: remainder below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && c_reg.peak |-> c_diff < MAG_W'(c_reg.count))
        else $error("mean quotient off by one");

    // an accepted summary is held in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        peak_valid && peak_ready |=> b_valid_reg)
        else $error("summary transfer lost");

endmodule

// ----- sv/local_peak_neighbor_mean_filter.sv -----
// ============================================================================
// local_peak_neighbor_mean_filter: 3x3 strict local peak replacement filter
// Raster pixel stream in, one result per pixel out, with frame size
// register, two line memories and a sliding 3x3 window.
// ============================================================================
// Unstalled, the block takes one item and gives up to one result per clock.
// Pixels of a square frame (side set by frame_size, 2 to 256, clamped) enter
// in raster order; the result for a pixel leaves once its lower neighbors
// are in, one row plus one pixel later, and after the frame's last pixel
// frame_size+1 drain items (command 1) push out the rest, the last result
// carrying frame_end. A drain item inside the frame is taken and dropped; a
// pixel item past the frame's last pixel acts as a drain item. Each result
// goes through four register stages (line memory read, mean summary, quotient,
// output); one item per cycle while unstalled, set by the single read and
// single write port of each 256 x 16 line memory. Writing frame_size restarts
// the frame; the user must do so only while idle, unenforced by the block.
// Line memories have no clearing pass; rows above the frame are never used.
module local_peak_neighbor_mean_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lpnm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lpnm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lpnm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  lpnm_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output lpnm_pkg::result_t                   result
);
    import lpnm_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0]       col_addr;
        logic signed [PIX_W-1:0] pixel;
        logic                    right_res;
        logic                    mid_res;
        logic                    has_up;
        logic                    has_down;
        logic                    has_left;
        logic                    has_right;
        logic [COORD_W-1:0]      row;
        logic [COORD_W-1:0]      column;
        logic                    frame_end;
    } stage_a_t;

    logic [SIZE_W-1:0]    frame_size_reg;
    logic [SIZE_W-1:0]    side;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;

    logic [SIZE_W-1:0] in_row_reg;
    logic [SIZE_W-1:0] in_row_next;
    logic [ADDR_W-1:0] in_col_reg;
    logic [ADDR_W-1:0] in_col_next;
    logic [ADDR_W-1:0] col;
    logic [SIZE_W-1:0] col_inc;
    logic [SIZE_W-1:0] row_full;
    logic [SIZE_W-1:0] col_full;
    logic              drain;
    logic              skip;
    logic              take;
    logic              frame_last;

    stage_a_t a_reg;
    stage_a_t a_next;
    logic     a_valid_reg;
    logic     a_has_res;
    logic     a_leave;

    logic signed [PIX_W-1:0] upper_mem [MAX_SIZE];
    logic signed [PIX_W-1:0] middle_mem [MAX_SIZE];
    logic signed [PIX_W-1:0] up_rd_reg;
    logic signed [PIX_W-1:0] mid_rd_reg;

    logic signed [PIX_W-1:0] win_reg [3][3];
    logic signed [PIX_W-1:0] win_sh [3][3];
    logic signed [PIX_W-1:0] nb [3][3];
    logic                    en [3][3];
    logic signed [PIX_W-1:0] center;
    logic signed [SUM_W-1:0] nb_sum;
    logic [CNT_W-1:0]        nb_cnt;
    logic                    all_below;

    peak_t peak_in;
    logic  peak_valid;
    logic  peak_ready;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];

    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_SIZE: prdata = APB_DATA_W'(frame_size_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_size_reg <= FRAME_SIZE_RESET;
        end
        else if (cfg_write && reg_idx == REG_FRAME_SIZE)
        begin
            frame_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // clamped frame side
    always_comb
    begin
        if (frame_size_reg < SIZE_W'(MIN_SIZE))
        begin
            side = SIZE_W'(MIN_SIZE);
        end
        else if (frame_size_reg > SIZE_W'(MAX_SIZE))
        begin
            side = SIZE_W'(MAX_SIZE);
        end
        else
        begin
            side = frame_size_reg;
        end
    end

    // raster position and result descriptor of the incoming item
    always_comb
    begin
        col        = (SIZE_W'(in_col_reg) >= side) ? '0 : in_col_reg;
        drain      = in_row_reg >= side;
        skip       = !drain && (item.command == CMD_DRAIN);
        take       = item_valid && item_ready && !skip;
        frame_last = (in_row_reg == side + SIZE_W'(1)) && (col == '0);
        col_inc    = SIZE_W'(col) + SIZE_W'(1);

        if (frame_last)
        begin
            in_row_next = '0;
            in_col_next = '0;
        end
        else if (col_inc >= side)
        begin
            in_row_next = in_row_reg + SIZE_W'(1);
            in_col_next = '0;
        end
        else
        begin
            in_row_next = in_row_reg;
            in_col_next = col_inc[ADDR_W-1:0];
        end

        a_next.right_res = (col == '0) && (in_row_reg >= SIZE_W'(2));
        a_next.mid_res   = (col != '0) && (in_row_reg != '0);
        row_full = a_next.right_res ? in_row_reg - SIZE_W'(2) : in_row_reg - SIZE_W'(1);
        col_full = a_next.right_res ? side - SIZE_W'(1) : SIZE_W'(col) - SIZE_W'(1);

        a_next.col_addr  = col;
        a_next.pixel     = drain ? '0 : item.pixel;
        a_next.has_up    = row_full != '0;
        a_next.has_down  = row_full < side - SIZE_W'(1);
        a_next.has_left  = col_full != '0;
        a_next.has_right = !a_next.right_res;
        a_next.row       = row_full[COORD_W-1:0];
        a_next.column    = col_full[COORD_W-1:0];
        a_next.frame_end = (row_full == side - SIZE_W'(1)) &&
                           (col_full == side - SIZE_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
        end
        else if (cfg_write && reg_idx == REG_FRAME_SIZE)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
        end
        else if (take)
        begin
            in_row_reg <= in_row_next;
            in_col_reg <= in_col_next;
        end
    end

    // window stage
    assign a_has_res  = a_reg.right_res || a_reg.mid_res;
    assign a_leave    = a_valid_reg && (!a_has_res || peak_ready);
    assign item_ready = !a_valid_reg || a_leave;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            a_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_reg <= a_next;
        end
    end

    // line memories: read at the new column, written as the window moves on
    always_ff @(posedge clk)
    begin
        if (a_leave)
        begin
            upper_mem[a_reg.col_addr] <= mid_rd_reg;
        end
        if (take)
        begin
            up_rd_reg <= upper_mem[col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_leave)
        begin
            middle_mem[a_reg.col_addr] <= a_reg.pixel;
        end
        if (take)
        begin
            mid_rd_reg <= middle_mem[col];
        end
    end

    // window shifted by one column with the new column on the right
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_sh[r][0] = win_reg[r][1];
            win_sh[r][1] = win_reg[r][2];
        end
        win_sh[0][2] = up_rd_reg;
        win_sh[1][2] = mid_rd_reg;
        win_sh[2][2] = a_reg.pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[r][k] <= '0;
                end
            end
        end
        else if (a_leave)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[r][k] <= win_sh[r][k];
                end
            end
        end
    end

    // neighborhood: right edge result uses the window before the shift
    always_comb
    begin
        center = a_reg.right_res ? win_reg[1][2] : win_sh[1][1];
        for (int r = 0; r < 3; r++)
        begin
            if (a_reg.right_res)
            begin
                nb[r][0] = win_reg[r][1];
                nb[r][1] = win_reg[r][2];
                nb[r][2] = '0;
            end
            else
            begin
                for (int k = 0; k < 3; k++)
                begin
                    nb[r][k] = win_sh[r][k];
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                en[r][k] = !(r == 1 && k == 1) &&
                           (r != 0 || a_reg.has_up) && (r != 2 || a_reg.has_down) &&
                           (k != 0 || a_reg.has_left) && (k != 2 || a_reg.has_right);
            end
        end
    end

    // sum, count and strict peak test over the in-frame neighbors
    always_comb
    begin
        nb_sum    = '0;
        nb_cnt    = '0;
        all_below = 1'b1;
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (en[r][k])
                begin
                    nb_sum = nb_sum + SUM_W'(nb[r][k]);
                    nb_cnt = nb_cnt + CNT_W'(1);
                    if (!(center > nb[r][k]))
                    begin
                        all_below = 1'b0;
                    end
                end
            end
        end

        peak_in.center    = center;
        peak_in.sum       = nb_sum;
        peak_in.count     = nb_cnt;
        peak_in.peak      = all_below && (nb_cnt != '0);
        peak_in.row       = a_reg.row;
        peak_in.column    = a_reg.column;
        peak_in.frame_end = a_reg.frame_end;
    end

    assign peak_valid = a_valid_reg && a_has_res;

    // mean divider and output register
    lpnm_mean u_mean (
        .clk          (clk),
        .rst_n        (rst_n),
        .peak_valid   (peak_valid),
        .peak_ready   (peak_ready),
        .peak_in      (peak_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // raster row never runs past the last drain row
    assert property (@(posedge clk) disable iff (!rst_n)
        in_row_reg <= side + SIZE_W'(1))
        else $error("raster row beyond drain rows");

    // a window step yields at most one result
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> !(a_reg.right_res && a_reg.mid_res))
        else $error("two results from one window step");

    // the frame end transfer restarts the raster position
    assert property (@(posedge clk) disable iff (!rst_n)
        take && frame_last |=> in_row_reg == '0 && in_col_reg == '0)
        else $error("frame did not restart");

    // line memory read and write in one cycle never hit the same column
    assert property (@(posedge clk) disable iff (!rst_n)
        take && a_leave && in_row_reg != '0 |-> col != a_reg.col_addr)
        else $error("line memory read and write collide");

endmodule
